>>> rtl/adpcm_voice_decoder_with_loop_assert.svh
// Assertion macros for the ADPCM voice decoder checker.
// Needs a clock named clk and a synchronous reset named rst in scope.
`ifndef ADPCM_VOICE_DECODER_WITH_LOOP_ASSERT_SVH
`define ADPCM_VOICE_DECODER_WITH_LOOP_ASSERT_SVH

// Property checked outside of reset
`define AVD_CHECK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Property checked on every edge, reset included
`define AVD_CHECK_ANY(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/avd_pkg.sv
// Shared types, constants and the step scale table of the ADPCM voice decoder.
// No dependencies.
package avd_pkg;

  localparam int ADDR_BITS_DEF = 25;
  localparam int SAMPLE_W      = 16;
  localparam int STEP_W        = 15;
  localparam int NIB_W         = 4;
  localparam int SCALE_W       = 10;
  localparam int CFG_IDX_W     = 3;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic [STEP_W-1:0]          step_t;
  typedef logic [NIB_W-1:0]           nib_t;

  // Request kinds carried on the input side
  localparam logic REQ_KEY_ON = 1'b0;
  localparam logic REQ_NIBBLE = 1'b1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_START = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_STOP  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LOOP_START   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LOOP_STOP    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_LOOP_ENABLE  = 3'd4;

  localparam step_t   STEP_MIN   = 15'd127;
  localparam step_t   STEP_MAX   = 15'h6000;
  localparam sample_t SAMPLE_MAX = 16'sh7FFF;
  localparam sample_t SAMPLE_MIN = -16'sh8000;

  // Status flags of one result
  typedef struct packed {
    logic playing;
    logic ended;
  } status_t;

  // Step scale factor in 1/256 units, indexed by the code magnitude
  function automatic logic [SCALE_W-1:0] step_scale(input logic [2:0] mag);
    logic [SCALE_W-1:0] f;
    case (mag)
      3'd4:    f = 10'h133;
      3'd5:    f = 10'h199;
      3'd6:    f = 10'h200;
      3'd7:    f = 10'h266;
      default: f = 10'h0E6;
    endcase
    return f;
  endfunction

endpackage

>>> rtl/adpcm_voice_decoder_with_loop.sv
// One ADPCM voice with one-shot or looped playback, stream in and stream out.
// Depends on avd_pkg and avd_voice.
// Throughput is one item per clock while the result stream does not stall. An accepted
// item waits in the input register; the decode and the voice state update are then
// combinational into the output register, which loads the result once it is free and
// offers it from there. The voice state feedback loop (sample, step, position) closes
// through that combinational update, which sets the rate. While a result waits, one more
// item is taken into the input register before the input side stalls.
module adpcm_voice_decoder_with_loop #(
  parameter int ADDR_BITS = avd_pkg::ADDR_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  // Input stream
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [7:0]                    s_tdata,   // [3:0] nibble, rest zero
  input  logic                          s_tuser,   // [0] req_type
  // Result stream
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // sample, next_address, playing, ended from bit 0 up, zero padded to bytes
  output logic [((avd_pkg::SAMPLE_W+ADDR_BITS+2+7)/8)*8-1:0] m_tdata,
  // Configuration writes
  input  logic                          cfg_we,
  input  logic [avd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ADDR_BITS-1:0]          cfg_data
);
  import avd_pkg::*;

  localparam int RES_W = SAMPLE_W + ADDR_BITS + 2;
  localparam int OUT_W = ((RES_W + 7) / 8) * 8;

  logic [ADDR_BITS-1:0] sample_start, sample_stop, loop_start, loop_stop;
  logic                 loop_enable;

  logic                 in_valid, in_req;
  nib_t                 in_nib;
  logic                 advance;

  sample_t              res_sample;
  logic [ADDR_BITS-1:0] res_address;
  status_t              res_status;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      sample_start <= '0;
      sample_stop  <= '0;
      loop_start   <= '0;
      loop_stop    <= '0;
      loop_enable  <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SAMPLE_START: sample_start <= cfg_data;
        REG_SAMPLE_STOP:  sample_stop  <= cfg_data;
        REG_LOOP_START:   loop_start   <= cfg_data;
        REG_LOOP_STOP:    loop_stop    <= cfg_data;
        REG_LOOP_ENABLE:  loop_enable  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Input register; item moves on when the output register is free
  assign advance  = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_req <= s_tuser;
      in_nib <= s_tdata[NIB_W-1:0];
    end
  end

  avd_voice #(.ADDR_BITS(ADDR_BITS)) u_voice (
    .clk          (clk),
    .rst          (rst),
    .advance      (advance),
    .req          (in_req),
    .nib          (in_nib),
    .sample_start (sample_start),
    .sample_stop  (sample_stop),
    .loop_start   (loop_start),
    .loop_stop    (loop_stop),
    .loop_enable  (loop_enable),
    .res_sample   (res_sample),
    .res_address  (res_address),
    .res_status   (res_status)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      m_tdata <= OUT_W'({res_status.ended, res_status.playing, res_address, res_sample});
    end
  end

endmodule

>>> rtl/avd_decode.sv
// ADPCM nibble arithmetic: sample update and step adaptation with clamps.
// Depends on avd_pkg.
module avd_decode (
  input  avd_pkg::sample_t sample,
  input  avd_pkg::step_t   step,
  input  avd_pkg::nib_t    nib,
  output avd_pkg::sample_t sample_next,
  output avd_pkg::step_t   step_next
);
  import avd_pkg::*;

  logic [3:0]                 mag;
  logic [STEP_W+3:0]          prod_d;
  logic [STEP_W:0]            quot;
  logic signed [SAMPLE_W+1:0] sum;
  logic [STEP_W+SCALE_W-1:0]  prod_s;
  logic [STEP_W+SCALE_W-9:0]  scaled;

  // Sample: step * (2m+1) / 8, truncated toward zero, sign applied after
  assign mag    = {nib[2:0], 1'b1};
  assign prod_d = step * mag;
  assign quot   = prod_d[STEP_W+3:3];

  always_comb begin
    if (nib[3]) begin
      sum = (SAMPLE_W+2)'(sample) - $signed({2'b00, quot});
    end else begin
      sum = (SAMPLE_W+2)'(sample) + $signed({2'b00, quot});
    end
    if (sum > (SAMPLE_W+2)'(SAMPLE_MAX)) begin
      sample_next = SAMPLE_MAX;
    end else if (sum < (SAMPLE_W+2)'(SAMPLE_MIN)) begin
      sample_next = SAMPLE_MIN;
    end else begin
      sample_next = sum[SAMPLE_W-1:0];
    end
  end

  // Step: step * scale / 256, clamped to the legal range
  assign prod_s = step * step_scale(nib[2:0]);
  assign scaled = prod_s[STEP_W+SCALE_W-1:8];

  always_comb begin
    if (scaled > (STEP_W+SCALE_W-8)'(STEP_MAX)) begin
      step_next = STEP_MAX;
    end else if (scaled < (STEP_W+SCALE_W-8)'(STEP_MIN)) begin
      step_next = STEP_MIN;
    end else begin
      step_next = scaled[STEP_W-1:0];
    end
  end

endmodule

>>> rtl/avd_voice.sv
// Voice state (sample, step, position, loop snapshot) and per-item control.
// Depends on avd_pkg and avd_decode.
module avd_voice #(
  parameter int ADDR_BITS = avd_pkg::ADDR_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 advance,
  input  logic                 req,
  input  avd_pkg::nib_t        nib,
  input  logic [ADDR_BITS-1:0] sample_start,
  input  logic [ADDR_BITS-1:0] sample_stop,
  input  logic [ADDR_BITS-1:0] loop_start,
  input  logic [ADDR_BITS-1:0] loop_stop,
  input  logic                 loop_enable,
  output avd_pkg::sample_t     res_sample,
  output logic [ADDR_BITS-1:0] res_address,
  output avd_pkg::status_t     res_status
);
  import avd_pkg::*;

  sample_t              cur_sample, cur_sample_next;
  step_t                cur_step, cur_step_next;
  logic [ADDR_BITS-1:0] position, position_next;
  sample_t              saved_sample, saved_sample_next;
  step_t                saved_step, saved_step_next;
  logic                 active, active_next;

  sample_t              src_sample, dec_sample;
  step_t                src_step, dec_step;
  logic [ADDR_BITS-1:0] pos_inc;
  logic                 at_loop_stop, at_loop_start, save_now;

  assign at_loop_stop  = position >= loop_stop;
  assign at_loop_start = position == loop_start;
  assign save_now      = !at_loop_stop && at_loop_start;
  assign pos_inc       = position + 1'b1;

  // A misaligned loop decodes from the restored snapshot
  assign src_sample = (loop_enable && at_loop_stop) ? saved_sample : cur_sample;
  assign src_step   = (loop_enable && at_loop_stop) ? saved_step   : cur_step;

  avd_decode u_decode (
    .sample      (src_sample),
    .step        (src_step),
    .nib         (nib),
    .sample_next (dec_sample),
    .step_next   (dec_step)
  );

  // Next state and result for the item in the input register
  always_comb begin
    cur_sample_next   = cur_sample;
    cur_step_next     = cur_step;
    position_next     = position;
    saved_sample_next = saved_sample;
    saved_step_next   = saved_step;
    active_next       = active;
    res_sample        = cur_sample;
    res_status.ended  = 1'b0;
    if (req == REQ_KEY_ON) begin
      position_next   = sample_start;
      cur_step_next   = STEP_MIN;
      cur_sample_next = '0;
      active_next     = 1'b1;
      res_sample      = '0;
    end else if (!active) begin
      res_sample = cur_sample;
    end else if (loop_enable) begin
      if (save_now) begin
        saved_sample_next = cur_sample;
        saved_step_next   = cur_step;
      end
      if (at_loop_stop && !at_loop_start) begin
        // Past the loop end off the loop start: restore only, nibble dropped
        cur_sample_next = saved_sample;
        cur_step_next   = saved_step;
        position_next   = loop_start;
        res_sample      = saved_sample;
      end else begin
        res_sample      = dec_sample;
        cur_sample_next = dec_sample;
        cur_step_next   = dec_step;
        position_next   = pos_inc;
        if (pos_inc >= loop_stop) begin
          cur_sample_next = save_now ? cur_sample : saved_sample;
          cur_step_next   = save_now ? cur_step   : saved_step;
          position_next   = loop_start;
        end
      end
    end else begin
      if (position >= sample_stop) begin
        active_next      = 1'b0;
        res_status.ended = 1'b1;
        res_sample       = cur_sample;
      end else begin
        cur_sample_next = dec_sample;
        cur_step_next   = dec_step;
        position_next   = pos_inc;
        res_sample      = dec_sample;
        if (pos_inc >= sample_stop) begin
          active_next      = 1'b0;
          res_status.ended = 1'b1;
        end
      end
    end
    res_address        = position_next;
    res_status.playing = active_next;
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_sample   <= '0;
      cur_step     <= '0;
      position     <= '0;
      saved_sample <= '0;
      saved_step   <= '0;
      active       <= 1'b0;
    end else if (advance) begin
      cur_sample   <= cur_sample_next;
      cur_step     <= cur_step_next;
      position     <= position_next;
      saved_sample <= saved_sample_next;
      saved_step   <= saved_step_next;
      active       <= active_next;
    end
  end

endmodule

>>> rtl/avd_checker.sv
// Port-level checks of the ADPCM voice decoder, bound to its top level.
// Depends on avd_pkg and adpcm_voice_decoder_with_loop_assert.svh.
`include "adpcm_voice_decoder_with_loop_assert.svh"

module avd_port_checks #(
  parameter int ADDR_BITS = avd_pkg::ADDR_BITS_DEF
) (
  input logic                                                  clk,
  input logic                                                  rst,
  input logic                                                  s_tvalid,
  input logic                                                  s_tready,
  input logic                                                  m_tvalid,
  input logic                                                  m_tready,
  input logic [((avd_pkg::SAMPLE_W+ADDR_BITS+2+7)/8)*8-1:0]    m_tdata
);
  import avd_pkg::*;

  localparam int PLAY_BIT  = SAMPLE_W + ADDR_BITS;
  localparam int ENDED_BIT = PLAY_BIT + 1;

  // A stalled result holds
  `AVD_CHECK(a_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "result changed while stalled")

  // End of playback is never reported while still playing
  `AVD_CHECK(a_end_stops, m_tvalid |-> !(m_tdata[ENDED_BIT] && m_tdata[PLAY_BIT]), "ended with playing set")

  // Nothing is offered right after a reset edge
  `AVD_CHECK_ANY(a_reset_empty, rst |=> !m_tvalid, "result valid after reset")

  // With the output side empty the input side can always take an item
  `AVD_CHECK(a_no_bubble_stall, !m_tvalid |-> s_tready, "input stalled with empty output")

  // Input accepted while the output is free shows a result once it has passed the input and output registers
  `AVD_CHECK(a_latency, s_tvalid && s_tready && !m_tvalid |=> ##1 m_tvalid, "item lost in flight")

endmodule

bind adpcm_voice_decoder_with_loop avd_port_checks #(.ADDR_BITS(ADDR_BITS)) u_avd_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
